### sv/pae_pkg.sv
// ----------------------------------------------------------------------------
// pae_pkg
// Shared types and constants for the positional array editor.
// ----------------------------------------------------------------------------
package pae_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 8;
    localparam int DATA_W   = 32;
    localparam int ACT_W    = 3;
    localparam int STAT_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_UPDATE = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_BAD   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_WRITE,
        S_SHIFT_DN,
        S_READ_WAIT
    } t_state;

endpackage

### sv/pae_ram.sv
// ----------------------------------------------------------------------------
// pae_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/positional_array_editor.sv
// ----------------------------------------------------------------------------
// positional_array_editor
// Dense ordered array of signed words with insert/delete/update/read at a position.
// ----------------------------------------------------------------------------
// Usage: drive i_action, i_position, i_value and raise start; the request is
// taken at a clock edge where start is high and busy is low. busy stays high
// until the result has been issued. Each request yields one result: o_valid
// is high for exactly one cycle with o_status, o_read_value and o_count.
// The receiver cannot stall; the result must be captured on that cycle.
// Clear, update, append and rejected requests set o_valid straight from
// idle; a read passes through S_READ_WAIT; an insert at p moves words
// up through S_SHIFT_UP (one RAM read/write per moved word), then writes
// the new word in S_INS_WRITE; a delete moves words down in S_SHIFT_DN,
// or goes straight from idle when deleting the last word.
// The next request is accepted in the cycle o_valid is high; the slowest
// request is an insert at 0 into an array one short of full, since every
// moved word goes through the single RAM write port.
// Reset (synchronous, active low) empties the array; RAM contents are not
// cleared since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_array_editor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pae_pkg::ACT_W-1:0]    i_action,
    input  logic [7:0]                   i_position,
    input  logic signed [31:0]           i_value,
    output logic                         o_valid,
    output logic [pae_pkg::STAT_W-1:0]   o_status,
    output logic signed [31:0]           o_read_value,
    output logic [7:0]                   o_count
);

    pae_pkg::t_state               r_state, n_state;
    logic [pae_pkg::CNT_W-1:0]     r_count, n_count;
    logic [pae_pkg::ADDR_W-1:0]    r_idx, n_idx;
    logic [pae_pkg::ADDR_W-1:0]    r_pos, n_pos;
    logic [pae_pkg::DATA_W-1:0]    r_val, n_val;
    logic                          r_valid, n_valid;
    pae_pkg::t_status              r_status, n_status;
    logic [pae_pkg::DATA_W-1:0]    r_rdval, n_rdval;

    logic                          ram_we;
    logic [pae_pkg::ADDR_W-1:0]    ram_waddr;
    logic [pae_pkg::DATA_W-1:0]    ram_wdata;
    logic [pae_pkg::ADDR_W-1:0]    ram_raddr;
    logic [pae_pkg::DATA_W-1:0]    ram_rdata;

    logic [pae_pkg::ADDR_W-1:0]    pos_a;
    logic [pae_pkg::CNT_W-1:0]     last_c;

    pae_ram #(
        .WIDTH (pae_pkg::DATA_W),
        .DEPTH (pae_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign pos_a  = i_position[pae_pkg::ADDR_W-1:0];
    assign last_c = r_count - pae_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pae_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_rdval  <= n_rdval;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_val     = r_val;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_rdval   = r_rdval;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;
        ram_raddr = r_idx;

        unique case (r_state)
            pae_pkg::S_IDLE: begin
                if (start) begin
                    n_status = pae_pkg::ST_OK;
                    n_rdval  = '0;
                    n_pos    = pos_a;
                    n_val    = i_value;
                    unique case (i_action) inside
                        pae_pkg::ACT_CLEAR: begin
                            n_count = '0;
                            n_valid = 1'b1;
                        end
                        pae_pkg::ACT_INSERT: begin
                            if (r_count >= pae_pkg::CNT_W'(pae_pkg::CAPACITY)) begin
                                n_status = pae_pkg::ST_FULL;
                                n_valid  = 1'b1;
                            end else if (i_position > r_count) begin
                                n_status = pae_pkg::ST_BAD;
                                n_valid  = 1'b1;
                            end else if (i_position == r_count) begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_a;
                                ram_wdata = i_value;
                                n_count   = r_count + pae_pkg::CNT_W'(1);
                                n_valid   = 1'b1;
                            end else begin
                                n_idx     = r_count[pae_pkg::ADDR_W-1:0];
                                ram_raddr = last_c[pae_pkg::ADDR_W-1:0];
                                n_state   = pae_pkg::S_SHIFT_UP;
                            end
                        end
                        pae_pkg::ACT_UPDATE, pae_pkg::ACT_DELETE, pae_pkg::ACT_READ: begin
                            if (r_count == '0) begin
                                n_status = pae_pkg::ST_EMPTY;
                                n_valid  = 1'b1;
                            end else if (i_position >= r_count) begin
                                n_status = pae_pkg::ST_BAD;
                                n_valid  = 1'b1;
                            end else if (i_action == pae_pkg::ACT_UPDATE) begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_a;
                                ram_wdata = i_value;
                                n_valid   = 1'b1;
                            end else if (i_action == pae_pkg::ACT_DELETE) begin
                                if (i_position == last_c) begin
                                    n_count = last_c;
                                    n_valid = 1'b1;
                                end else begin
                                    n_idx     = pos_a;
                                    ram_raddr = pos_a + pae_pkg::ADDR_W'(1);
                                    n_state   = pae_pkg::S_SHIFT_DN;
                                end
                            end else begin
                                ram_raddr = pos_a;
                                n_state   = pae_pkg::S_READ_WAIT;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            pae_pkg::S_SHIFT_UP: begin
                // move word idx-1 (read last cycle) into idx
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                ram_raddr = r_idx - pae_pkg::ADDR_W'(2);
                n_idx     = r_idx - pae_pkg::ADDR_W'(1);
                if (r_idx == r_pos + pae_pkg::ADDR_W'(1)) begin
                    n_state = pae_pkg::S_INS_WRITE;
                end
            end
            pae_pkg::S_INS_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_val;
                n_count   = r_count + pae_pkg::CNT_W'(1);
                n_valid   = 1'b1;
                n_state   = pae_pkg::S_IDLE;
            end
            pae_pkg::S_SHIFT_DN: begin
                // move word idx+1 (read last cycle) into idx
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                ram_raddr = r_idx + pae_pkg::ADDR_W'(2);
                n_idx     = r_idx + pae_pkg::ADDR_W'(1);
                if ({1'b0, r_idx} + pae_pkg::CNT_W'(2) == r_count) begin
                    n_count = last_c;
                    n_valid = 1'b1;
                    n_state = pae_pkg::S_IDLE;
                end
            end
            pae_pkg::S_READ_WAIT: begin
                n_rdval = ram_rdata;
                n_valid = 1'b1;
                n_state = pae_pkg::S_IDLE;
            end
            default: begin
                n_state = pae_pkg::S_IDLE;
            end
        endcase
    end

    assign busy         = (r_state != pae_pkg::S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_read_value = r_rdval;
    assign o_count      = r_count;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Request-level check of the positional array editor. A directed table covers
// the empty, bad-position, full-range value and unused-action cases, then
// random requests push the array to capacity and back down several times.
// Every result is matched in order against the row's expected result or a shadow copy of the array.
// ----------------------------------------------------------------------------
module tb_top;
    import pae_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;
    localparam int RANDOM_REQUESTS = 1327;
    localparam int DIRECTED_COUNT  = 23;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] read_value;
        logic [7:0]         count;
    } t_edit_result;

    typedef struct packed {
        logic [ACT_W-1:0]   act;
        logic [7:0]         pos;
        logic signed [31:0] val;
        logic               typed;
        t_status            status;
        logic signed [31:0] read_value;
        logic [7:0]         count;
    } t_stim_row;

    // typed rows carry their expected result; others use the shadow array
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{ACT_READ,        8'd0,   32'd0,          1'b1, ST_EMPTY, 32'd0,          8'd0},
        '{ACT_UPDATE,      8'd0,   32'd5,          1'b1, ST_EMPTY, 32'd0,          8'd0},
        '{ACT_DELETE,      8'd0,   32'd0,          1'b1, ST_EMPTY, 32'd0,          8'd0},
        '{ACT_INSERT,      8'd1,   32'd9,          1'b1, ST_BAD,   32'd0,          8'd0},
        '{ACT_INSERT,      8'd0,   32'h8000_0000,  1'b1, ST_OK,    32'd0,          8'd1},
        '{ACT_INSERT,      8'd1,   32'h7fff_ffff,  1'b1, ST_OK,    32'd0,          8'd2},
        '{ACT_READ,        8'd0,   32'd0,          1'b1, ST_OK,    32'h8000_0000,  8'd2},
        '{ACT_READ,        8'd1,   32'd0,          1'b1, ST_OK,    32'h7fff_ffff,  8'd2},
        '{ACT_INSERT,      8'd0,   32'hffff_ffff,  1'b0, ST_OK,    32'd0,          8'd0},
        '{ACT_INSERT,      8'd3,   32'd0,          1'b0, ST_OK,    32'd0,          8'd0},
        '{ACT_READ,        8'd2,   32'd0,          1'b0, ST_OK,    32'd0,          8'd0},
        '{ACT_READ,        8'd4,   32'd0,          1'b1, ST_BAD,   32'd0,          8'd4},
        '{ACT_UPDATE,      8'd255, 32'd1,          1'b1, ST_BAD,   32'd0,          8'd4},
        '{ACT_UPDATE,      8'd1,   32'h5555_aaaa,  1'b0, ST_OK,    32'd0,          8'd0},
        '{ACT_DELETE,      8'd0,   32'd0,          1'b0, ST_OK,    32'd0,          8'd0},
        '{ACT_DELETE,      8'd2,   32'd0,          1'b0, ST_OK,    32'd0,          8'd0},
        '{ACT_READ,        8'd1,   32'd0,          1'b0, ST_OK,    32'd0,          8'd0},
        '{ACT_SPARE_FIRST, 8'd255, 32'hffff_ffff,  1'b1, ST_OK,    32'd0,          8'd2},
        '{ACT_SPARE_LAST,  8'd0,   32'd0,          1'b1, ST_OK,    32'd0,          8'd2},
        '{ACT_INSERT,      8'd200, 32'd3,          1'b1, ST_BAD,   32'd0,          8'd2},
        '{ACT_CLEAR,       8'd0,   32'd0,          1'b1, ST_OK,    32'd0,          8'd0},
        '{ACT_CLEAR,       8'd0,   32'd0,          1'b1, ST_OK,    32'd0,          8'd0},
        '{ACT_READ,        8'd0,   32'd0,          1'b1, ST_EMPTY, 32'd0,          8'd0}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [ACT_W-1:0]           i_action;
    logic [7:0]                 i_position;
    logic signed [31:0]         i_value;
    logic                       o_valid;
    logic [STAT_W-1:0]          o_status;
    logic signed [31:0]         o_read_value;
    logic [7:0]                 o_count;

    logic signed [31:0]         shadow_words [CAPACITY];
    int                         shadow_count;
    t_edit_result               pending_results [$];
    int                         fail_count;
    bit                         idle_free;
    bit                         growing;

    positional_array_editor i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_count      (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic t_edit_result edit_shadow_array(input logic [ACT_W-1:0] act,
                                                       input logic [7:0] pos,
                                                       input logic signed [31:0] val);
        t_edit_result res;
        int           p;
        int           i;
        res.status     = ST_OK;
        res.read_value = '0;
        p = int'(pos);
        case (act) inside
            ACT_CLEAR: begin
                shadow_count = 0;
            end
            ACT_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (p > shadow_count) begin
                    res.status = ST_BAD;
                end else begin
                    for (i = shadow_count; i > p; i--) shadow_words[i] = shadow_words[i-1];
                    shadow_words[p] = val;
                    shadow_count++;
                end
            end
            ACT_UPDATE, ACT_DELETE, ACT_READ: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (p >= shadow_count) begin
                    res.status = ST_BAD;
                end else if (act == ACT_UPDATE) begin
                    shadow_words[p] = val;
                end else if (act == ACT_DELETE) begin
                    for (i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                end else begin
                    res.read_value = shadow_words[p];
                end
            end
            default: ;
        endcase
        res.count = shadow_count[7:0];
        return res;
    endfunction

    function automatic int idle_cycles();
        int r;
        if ($urandom_range(0, 99) == 0) idle_free = ~idle_free;
        if (idle_free) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 150);
    endfunction

    // called at a rising edge; returns at the edge that takes the request
    task automatic issue_request(input logic [ACT_W-1:0] act, input logic [7:0] pos,
                                 input logic signed [31:0] val, input bit typed,
                                 input t_edit_result typed_res);
        int           idle;
        t_edit_result predicted;
        idle = idle_cycles();
        if (idle > 0) begin
            start <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_action   <= act;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = edit_shadow_array(act, pos, val);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_edit_result exp_res;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d count %0d", o_status, o_count);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    fail_count++;
                end
                if (o_read_value !== exp_res.read_value) begin
                    $error("read_value: expected %h, got %h", exp_res.read_value, o_read_value);
                    fail_count++;
                end
                if (o_count !== exp_res.count) begin
                    $error("count: expected %0d, got %0d", exp_res.count, o_count);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_edit_result       typed_res;
        t_stim_row          row;
        logic [ACT_W-1:0]   act;
        logic [7:0]         pos;
        logic signed [31:0] val;
        int                 r;
        int                 n;
        int                 insert_top;

        fail_count   = 0;
        shadow_count = 0;
        idle_free    = 1'b0;
        growing      = 1'b1;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_action   <= ACT_CLEAR;
        i_position <= '0;
        i_value    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIRECTED_COUNT; n++) begin
            row = DIRECTED_ROWS[n];
            typed_res.status     = row.status;
            typed_res.read_value = row.read_value;
            typed_res.count      = row.count;
            issue_request(row.act, row.pos, row.val, row.typed, typed_res);
        end

        typed_res = '0;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (shadow_count == CAPACITY) growing = 1'b0;
            else if (shadow_count == 0) growing = 1'b1;
            insert_top = growing ? 500 : 220;
            r   = $urandom_range(0, 999);
            val = random_word();
            pos = '0;
            if (r < 5 && !growing) begin
                act = ACT_CLEAR;
            end else if (r < 35) begin
                act = ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
                pos = 8'($urandom_range(0, 255));
            end else if (r < 70) begin
                act = ACT_W'($urandom_range(ACT_INSERT, ACT_READ));
                pos = 8'($urandom_range(0, 255));
            end else if (r < insert_top) begin
                act = ACT_INSERT;
                pos = ($urandom_range(0, 3) == 0) ? 8'(shadow_count)
                                                  : 8'($urandom_range(0, shadow_count));
            end else begin
                if (r < 620) act = ACT_DELETE;
                else if (r < 780) act = ACT_UPDATE;
                else act = ACT_READ;
                if (shadow_count > 0) pos = 8'($urandom_range(0, shadow_count - 1));
            end
            issue_request(act, pos, val, 1'b0, typed_res);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
